[sv/plsd_pkg.sv]
// types and constants shared by the point to line segment distance pipeline
// no dependencies
package plsd_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int DIST_WIDTH  = 32;

	// differences of two coordinates, their products and sums
	localparam int DIFF_W  = COORD_WIDTH + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int SUM_W   = PROD_W + 2;
	localparam int CROSS_W = PROD_W + 1;
	localparam int MAG_W   = PROD_W;
	localparam int LO_W    = 32;
	localparam int HI_W    = MAG_W - LO_W;
	localparam int NUM_W   = 2 * MAG_W + 2;
	localparam int DEN_W   = PROD_W;
	localparam int QACC_W  = DEN_W + DIST_WIDTH;

	typedef enum logic [1:0] {
		REGION_INTERIOR = 2'd0,
		REGION_START    = 2'd1,
		REGION_END      = 2'd2
	} region_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] point_x;
		logic signed [COORD_WIDTH-1:0] point_y;
		logic signed [COORD_WIDTH-1:0] point_z;
		logic signed [COORD_WIDTH-1:0] start_x;
		logic signed [COORD_WIDTH-1:0] start_y;
		logic signed [COORD_WIDTH-1:0] start_z;
		logic signed [COORD_WIDTH-1:0] end_x;
		logic signed [COORD_WIDTH-1:0] end_y;
		logic signed [COORD_WIDTH-1:0] end_z;
	} query_t;

	typedef struct packed {
		logic [DIST_WIDTH-1:0] distance;
		region_t               region;
		logic                  degenerate;
	} result_t;

endpackage

[sv/point_line_segment_distance.sv]
// point to line or segment distance in 3d: differences, products, cross product,
// region decision and a pipelined bit-per-stage square root of a ratio; uses plsd_pkg
// throughput: one query a cycle; busy is always low since every stage advances each cycle
// the root takes 32 stages, one result bit each, with a wide compare and subtract per stage
// reset: arst_n clears all valid bits and sets segment_mode to 1; payload registers keep junk
module point_line_segment_distance
	import plsd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  query_t  query,
	input  logic    cfg_we,
	input  logic    cfg_data,
	output logic    done,
	output result_t result
);

	logic segment_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segment_mode_q <= 1'b1;
		end else if (cfg_we) begin
			segment_mode_q <= cfg_data;
		end
	end

	assign busy = 1'b0;

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic root_v [33];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// stage 1: differences
	logic signed [COORD_WIDTH-1:0] pc [3];
	logic signed [COORD_WIDTH-1:0] sc [3];
	logic signed [COORD_WIDTH-1:0] ec [3];

	always_comb begin
		pc[0] = query.point_x;
		pc[1] = query.point_y;
		pc[2] = query.point_z;
		sc[0] = query.start_x;
		sc[1] = query.start_y;
		sc[2] = query.start_z;
		ec[0] = query.end_x;
		ec[1] = query.end_y;
		ec[2] = query.end_z;
	end

	logic signed [DIFF_W-1:0] a_s1 [3];
	logic signed [DIFF_W-1:0] d_s1 [3];
	logic signed [DIFF_W-1:0] b_s1 [3];
	logic                     degen_s1, mode_s1;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			a_s1[i] <= DIFF_W'(pc[i]) - DIFF_W'(sc[i]);
			d_s1[i] <= DIFF_W'(ec[i]) - DIFF_W'(sc[i]);
			b_s1[i] <= DIFF_W'(pc[i]) - DIFF_W'(ec[i]);
		end
		degen_s1 <= (query.start_x == query.end_x) && (query.start_y == query.end_y)
			&& (query.start_z == query.end_z);
		mode_s1  <= segment_mode_q;
	end

	// stage 2: products
	logic signed [PROD_W-1:0] aa_s2 [3];
	logic signed [PROD_W-1:0] dd_s2 [3];
	logic signed [PROD_W-1:0] bb_s2 [3];
	logic signed [PROD_W-1:0] ad_s2 [3];
	logic signed [PROD_W-1:0] cp_s2 [3];
	logic signed [PROD_W-1:0] cn_s2 [3];
	logic                     degen_s2, mode_s2;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			aa_s2[i] <= a_s1[i] * a_s1[i];
			dd_s2[i] <= d_s1[i] * d_s1[i];
			bb_s2[i] <= b_s1[i] * b_s1[i];
			ad_s2[i] <= a_s1[i] * d_s1[i];
		end
		// cross product a x d, positive and negative terms
		cp_s2[0] <= a_s1[1] * d_s1[2];
		cn_s2[0] <= a_s1[2] * d_s1[1];
		cp_s2[1] <= a_s1[2] * d_s1[0];
		cn_s2[1] <= a_s1[0] * d_s1[2];
		cp_s2[2] <= a_s1[0] * d_s1[1];
		cn_s2[2] <= a_s1[1] * d_s1[0];
		degen_s2 <= degen_s1;
		mode_s2  <= mode_s1;
	end

	// stage 3: sums
	logic signed [SUM_W-1:0]   aa_s3, dd_s3, bb_s3, t_s3;
	logic signed [CROSS_W-1:0] c_s3 [3];
	logic                      degen_s3, mode_s3;

	always_ff @(posedge clk) begin
		aa_s3 <= SUM_W'(aa_s2[0]) + SUM_W'(aa_s2[1]) + SUM_W'(aa_s2[2]);
		dd_s3 <= SUM_W'(dd_s2[0]) + SUM_W'(dd_s2[1]) + SUM_W'(dd_s2[2]);
		bb_s3 <= SUM_W'(bb_s2[0]) + SUM_W'(bb_s2[1]) + SUM_W'(bb_s2[2]);
		t_s3  <= SUM_W'(ad_s2[0]) + SUM_W'(ad_s2[1]) + SUM_W'(ad_s2[2]);
		for (int i = 0; i < 3; i++) begin
			c_s3[i] <= CROSS_W'(cp_s2[i]) - CROSS_W'(cn_s2[i]);
		end
		degen_s3 <= degen_s2;
		mode_s3  <= mode_s2;
	end

	// stage 4: region decision and cross magnitudes
	region_t region_c4;

	always_comb begin
		priority if (degen_s3) begin
			region_c4 = REGION_START;
		end else if (mode_s3 && t_s3 < 0) begin
			region_c4 = REGION_START;
		end else if (mode_s3 && t_s3 > dd_s3) begin
			region_c4 = REGION_END;
		end else begin
			region_c4 = REGION_INTERIOR;
		end
	end

	logic [MAG_W-1:0] cm_s4 [3];
	logic [DEN_W-1:0] aa_s4, dd_s4, bb_s4;
	region_t          region_s4;
	logic             degen_s4;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			cm_s4[i] <= c_s3[i][CROSS_W-1] ? MAG_W'(-c_s3[i]) : MAG_W'(c_s3[i]);
		end
		aa_s4     <= DEN_W'(aa_s3);
		dd_s4     <= DEN_W'(dd_s3);
		bb_s4     <= DEN_W'(bb_s3);
		region_s4 <= region_c4;
		degen_s4  <= degen_s3;
	end

	// stage 5: partial products of the cross magnitude squares
	logic [2*HI_W-1:0]      hh_s5 [3];
	logic [HI_W+LO_W-1:0]   hl_s5 [3];
	logic [2*LO_W-1:0]      ll_s5 [3];
	logic [DEN_W-1:0]       aa_s5, dd_s5, bb_s5;
	region_t                region_s5;
	logic                   degen_s5;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			hh_s5[i] <= cm_s4[i][MAG_W-1:LO_W] * cm_s4[i][MAG_W-1:LO_W];
			hl_s5[i] <= cm_s4[i][MAG_W-1:LO_W] * cm_s4[i][LO_W-1:0];
			ll_s5[i] <= cm_s4[i][LO_W-1:0] * cm_s4[i][LO_W-1:0];
		end
		aa_s5     <= aa_s4;
		dd_s5     <= dd_s4;
		bb_s5     <= bb_s4;
		region_s5 <= region_s4;
		degen_s5  <= degen_s4;
	end

	// stage 6: each cross component squared
	logic [NUM_W-1:0] sq_s6 [3];
	logic [DEN_W-1:0] aa_s6, dd_s6, bb_s6;
	region_t          region_s6;
	logic             degen_s6;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s6[i] <= (NUM_W'(hh_s5[i]) << (2 * LO_W)) + (NUM_W'(hl_s5[i]) << (LO_W + 1))
				+ NUM_W'(ll_s5[i]);
		end
		aa_s6     <= aa_s5;
		dd_s6     <= dd_s5;
		bb_s6     <= bb_s5;
		region_s6 <= region_s5;
		degen_s6  <= degen_s5;
	end

	// stage 7: numerator and denominator of the squared distance
	logic [NUM_W-1:0]  rem_s [33];
	logic [QACC_W-1:0] qacc_s [33];
	logic [DEN_W-1:0]  den_s [33];
	logic [DIST_WIDTH-1:0] root_s [33];
	region_t           region_s [33];
	logic              degen_s [33];

	always_ff @(posedge clk) begin
		unique case (region_s6)
			REGION_INTERIOR: begin
				rem_s[0] <= sq_s6[0] + sq_s6[1] + sq_s6[2];
				den_s[0] <= dd_s6;
			end
			REGION_END: begin
				rem_s[0] <= NUM_W'(bb_s6);
				den_s[0] <= DEN_W'(1);
			end
			default: begin
				rem_s[0] <= NUM_W'(aa_s6);
				den_s[0] <= DEN_W'(1);
			end
		endcase
		qacc_s[0]   <= '0;
		root_s[0]   <= '0;
		region_s[0] <= region_s6;
		degen_s[0]  <= degen_s6;
	end

	assign root_v[0] = v_s7;

	// root stages: rem holds num - r*r*den, qacc holds r*den
	for (genvar g = 0; g < DIST_WIDTH; g++) begin : g_root
		localparam int B = DIST_WIDTH - 1 - g;
		logic [NUM_W-1:0] term;

		assign term = (NUM_W'(qacc_s[g]) << (B + 1)) + (NUM_W'(den_s[g]) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				root_v[g+1] <= 1'b0;
			end else begin
				root_v[g+1] <= root_v[g];
			end
		end

		always_ff @(posedge clk) begin
			if (rem_s[g] >= term) begin
				rem_s[g+1]  <= rem_s[g] - term;
				qacc_s[g+1] <= qacc_s[g] + (QACC_W'(den_s[g]) << B);
				root_s[g+1] <= root_s[g] | (DIST_WIDTH'(1) << B);
			end else begin
				rem_s[g+1]  <= rem_s[g];
				qacc_s[g+1] <= qacc_s[g];
				root_s[g+1] <= root_s[g];
			end
			den_s[g+1]    <= den_s[g];
			region_s[g+1] <= region_s[g];
			degen_s[g+1]  <= degen_s[g];
		end
	end

	assign done              = root_v[DIST_WIDTH];
	assign result.distance   = root_s[DIST_WIDTH];
	assign result.region     = region_s[DIST_WIDTH];
	assign result.degenerate = degen_s[DIST_WIDTH];

	a_degen_start: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.degenerate |-> result.region == REGION_START)
		else $error("degenerate word not measured to start");

	a_end_needs_mode: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && region_s4 == REGION_END |-> !degen_s4 && $past(mode_s3))
		else $error("end clamp without segment mode");

	a_line_interior: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !degen_s4 && !$past(mode_s3) |-> region_s4 == REGION_INTERIOR)
		else $error("line mode word clamped");

	a_point_den: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 && region_s[0] != REGION_INTERIOR |-> den_s[0] == DEN_W'(1))
		else $error("clamped word with non-unit denominator");

endmodule
